[rtl/la_pkg.sv]
package la_pkg;

  // Line store sizing
  localparam int unsigned LINE_BUF_SIZE = 64;
  localparam int unsigned LINE_CAP      = LINE_BUF_SIZE - 1;
  localparam int unsigned FILL_W        = $clog2(LINE_BUF_SIZE);
  localparam int unsigned ADDR_W        = (LINE_CAP > 1) ? $clog2(LINE_CAP) : 1;

  // Field widths
  localparam int unsigned CHAR_W   = 8;
  localparam int unsigned LEN_W    = 6;
  localparam int unsigned OUT_TD_W = ((CHAR_W + LEN_W + 7) / 8) * 8;
  localparam int unsigned OUT_PAD_W = OUT_TD_W - CHAR_W - LEN_W;

  // Item kinds and control characters
  localparam logic KIND_BYTE   = 1'b0;
  localparam logic KIND_RESYNC = 1'b1;
  localparam logic [CHAR_W-1:0] CH_LF = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR = 8'h0D;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_LOAD
  } la_state_e;

  // Line store access from the controller
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [CHAR_W-1:0] wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;

  // Load strobe for the output register
  typedef struct packed {
    logic             load;
    logic             last;
    logic [LEN_W-1:0] length;
  } out_load_t;

endpackage

[rtl/la_line_ram.sv]
module la_line_ram #(
  parameter int unsigned DEPTH = 63,
  parameter int unsigned WIDTH = 8,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/la_ctrl.sv]
module la_ctrl (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       in_kind_i,
  input  logic [la_pkg::CHAR_W-1:0]  in_byte_i,
  input  logic                       out_free_i,
  output la_pkg::ram_req_t           ram_req_o,
  output la_pkg::out_load_t          out_load_o
);

  import la_pkg::*;

  la_state_e         state_q, state_d;
  logic [FILL_W-1:0] fill_q, fill_d;
  logic              discard_q, discard_d;
  logic [FILL_W-1:0] len_q, len_d;
  logic [ADDR_W-1:0] idx_q, idx_d;

  logic in_acc, is_byte, is_lf, is_cr, room, start_rd, idx_last;

  // input decode
  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i & in_ready_o;
  assign is_byte    = (in_kind_i == KIND_BYTE);
  assign is_lf      = is_byte & (in_byte_i == CH_LF);
  assign is_cr      = is_byte & (in_byte_i == CH_CR);
  assign room       = (fill_q < FILL_W'(LINE_CAP));
  assign start_rd   = in_acc & is_lf & ~discard_q & (fill_q != '0);
  assign idx_last   = ((FILL_W'(idx_q) + FILL_W'(1)) == len_q);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_rd) state_d = ST_READ;
      end
      ST_READ: begin
        if (out_free_i) state_d = ST_LOAD;
      end
      ST_LOAD: begin
        state_d = idx_last ? ST_IDLE : ST_READ;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // line state update
  always_comb begin
    fill_d    = fill_q;
    discard_d = discard_q;
    len_d     = len_q;
    idx_d     = idx_q;
    if (in_acc) begin
      if (!is_byte) begin
        fill_d    = '0;
        discard_d = 1'b1;
      end else if (is_lf) begin
        fill_d    = '0;
        discard_d = 1'b0;
        len_d     = fill_q;
        idx_d     = '0;
      end else if (!is_cr && !discard_q) begin
        if (room) fill_d = fill_q + FILL_W'(1);
        else      discard_d = 1'b1;
      end
    end
    if (state_q == ST_LOAD) begin
      idx_d = idx_q + ADDR_W'(1);
    end
  end

  // store and output register strobes
  always_comb begin
    ram_req_o.we     = in_acc & is_byte & ~is_lf & ~is_cr & ~discard_q & room;
    ram_req_o.waddr  = fill_q[ADDR_W-1:0];
    ram_req_o.wdata  = in_byte_i;
    ram_req_o.re     = 1'b0;
    ram_req_o.raddr  = idx_q;
    out_load_o.load   = 1'b0;
    out_load_o.last   = idx_last;
    out_load_o.length = len_q[LEN_W-1:0];
    unique case (state_q)
      ST_IDLE: ;
      ST_READ: ram_req_o.re = out_free_i;
      ST_LOAD: out_load_o.load = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      fill_q    <= '0;
      discard_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      fill_q    <= fill_d;
      discard_q <= discard_d;
    end
  end

  always_ff @(posedge clk_i) begin
    len_q <= len_d;
    idx_q <= idx_d;
  end

endmodule

[rtl/la_out_reg.sv]
module la_out_reg (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  la_pkg::out_load_t         load_i,
  input  logic [la_pkg::CHAR_W-1:0] char_i,
  output logic                      free_o,
  output logic                      valid_o,
  input  logic                      ready_i,
  output logic [la_pkg::CHAR_W-1:0] char_o,
  output logic [la_pkg::LEN_W-1:0]  length_o,
  output logic                      last_o
);

  import la_pkg::*;

  logic              valid_q, valid_d;
  logic [CHAR_W-1:0] char_q;
  logic [LEN_W-1:0]  len_q;
  logic              last_q;

  // empty now or emptied at this edge
  assign free_o = ~valid_q | ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i.load)  valid_d = 1'b1;
    else if (ready_i) valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i.load) begin
      char_q <= char_i;
      len_q  <= load_i.length;
      last_q <= load_i.last;
    end
  end

  assign valid_o  = valid_q;
  assign char_o   = char_q;
  assign length_o = len_q;
  assign last_o   = last_q;

endmodule

[rtl/line_assembler_core.sv]
// Line assembler: builds text lines from a received byte stream.
// Input channel s_axis: one word per received byte (tuser = 0) or a
// resync after receive overflow (tuser = 1). CR is ignored, other bytes
// are stored until 63 are held; a further byte drops the rest of the line.
// Output channel m_axis: on LF, a non-empty, not dropped line is sent one
// character per word, with the line length and tlast on the last character.
// Throughput: one input word per cycle while a line is being gathered.
// After an LF that starts a line, the input stalls while the line store is
// read out: one store read and then one output load per character. After
// the LF is accepted, the first character passes through the store read
// register and the output register before it shows on m_axis.
// When the receiver stalls, the output word holds and the next store read
// waits, so the readout pauses without loss.
// Reset clears the state, the fill count, the discard flag and the output valid; the
// line store needs no clearing, entries are only read after being written.
module line_assembler_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [la_pkg::CHAR_W-1:0]    s_axis_tdata,   // [7:0] rx_byte
  input  logic                         s_axis_tuser,   // [0] kind
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [la_pkg::OUT_TD_W-1:0]  m_axis_tdata,   // [7:0] line_char, [13:8] line_length
  output logic                         m_axis_tlast    // line_last
);

  import la_pkg::*;

  ram_req_t          ram_req;
  out_load_t         out_load;
  logic              out_free;
  logic [CHAR_W-1:0] rd_char;
  logic [CHAR_W-1:0] out_char;
  logic [LEN_W-1:0]  out_len;

  la_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_kind_i  (s_axis_tuser),
    .in_byte_i  (s_axis_tdata),
    .out_free_i (out_free),
    .ram_req_o  (ram_req),
    .out_load_o (out_load)
  );

  la_line_ram #(
    .DEPTH (LINE_CAP),
    .WIDTH (CHAR_W),
    .AW    (ADDR_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_req.we),
    .waddr_i (ram_req.waddr),
    .wdata_i (ram_req.wdata),
    .re_i    (ram_req.re),
    .raddr_i (ram_req.raddr),
    .rdata_o (rd_char)
  );

  la_out_reg u_out (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (out_load),
    .char_i   (rd_char),
    .free_o   (out_free),
    .valid_o  (m_axis_tvalid),
    .ready_i  (m_axis_tready),
    .char_o   (out_char),
    .length_o (out_len),
    .last_o   (m_axis_tlast)
  );

  assign m_axis_tdata = {{OUT_PAD_W{1'b0}}, out_len, out_char};

endmodule

[rtl/la_checker.sv]
module la_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        s_axis_tready,
  input logic                        m_axis_tvalid,
  input logic                        m_axis_tready,
  input logic [la_pkg::OUT_TD_W-1:0] m_axis_tdata,
  input logic                        m_axis_tlast
);

  import la_pkg::*;

  // stalled output word keeps valid
  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("m_axis_tvalid dropped while stalled");

  // stalled output word keeps its payload
  a_data_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("m_axis payload changed while stalled");

  // an emitted line is never empty
  a_len_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[CHAR_W +: LEN_W] != '0)
    else $error("line length zero");

  // input stays stalled until the last character of a line is loaded
  a_in_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
    else $error("input accepted during line readout");

endmodule

bind line_assembler_core la_checker u_la_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
